/* hw/rtl/twi_seh_pkg.sv */
// Shared types, status codes and helpers for the two-wire status event handler.
// No dependencies; imported by the top level and the core.
`default_nettype none

package twi_seh_pkg;

  localparam int SEND_DEPTH_DEF = 32;
  localparam int RECV_DEPTH_DEF = 32;

  localparam int IDX_W  = 6;   // send and receive indices, saturate at 63
  localparam int BI_W   = 5;   // send buffer load index
  localparam int SI_W   = 5;   // store index field
  localparam int LIM_W  = 9;   // wide enough to hold a depth of up to 256
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W  = 8;

  localparam logic [IDX_W-1:0] IDX_MAX = '1;

  // bus_state codes
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_SRX  = 2'd1;
  localparam logic [1:0] MODE_STX  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEV_ADDR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MT_LEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MR_LEN   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ST_LEN   = 2'd3;

  // status codes, low three bits masked off
  localparam logic [7:0] ST_BUS_ERROR     = 8'h00;
  localparam logic [7:0] ST_START         = 8'h08;
  localparam logic [7:0] ST_REP_START     = 8'h10;
  localparam logic [7:0] ST_MT_SLA_ACK    = 8'h18;
  localparam logic [7:0] ST_MT_SLA_NACK   = 8'h20;
  localparam logic [7:0] ST_MT_DATA_ACK   = 8'h28;
  localparam logic [7:0] ST_MT_DATA_NACK  = 8'h30;
  localparam logic [7:0] ST_ARB_LOST      = 8'h38;
  localparam logic [7:0] ST_MR_SLA_ACK    = 8'h40;
  localparam logic [7:0] ST_MR_SLA_NACK   = 8'h48;
  localparam logic [7:0] ST_MR_DATA_ACK   = 8'h50;
  localparam logic [7:0] ST_MR_DATA_NACK  = 8'h58;
  localparam logic [7:0] ST_SR_SLA_ACK    = 8'h60;
  localparam logic [7:0] ST_SR_ARB_SLA    = 8'h68;
  localparam logic [7:0] ST_SR_GCALL      = 8'h70;
  localparam logic [7:0] ST_SR_ARB_GCALL  = 8'h78;
  localparam logic [7:0] ST_SR_DATA_ACK   = 8'h80;
  localparam logic [7:0] ST_SR_DATA_NACK  = 8'h88;
  localparam logic [7:0] ST_SR_GC_ACK     = 8'h90;
  localparam logic [7:0] ST_SR_GC_NACK    = 8'h98;
  localparam logic [7:0] ST_SR_STOP       = 8'hA0;
  localparam logic [7:0] ST_ST_SLA_ACK    = 8'hA8;
  localparam logic [7:0] ST_ST_ARB_SLA    = 8'hB0;
  localparam logic [7:0] ST_ST_DATA_ACK   = 8'hB8;
  localparam logic [7:0] ST_ST_DATA_NACK  = 8'hC0;
  localparam logic [7:0] ST_ST_LAST_DATA  = 8'hC8;

  localparam logic [7:0] STATUS_MASK = 8'hF8;
  localparam logic [7:0] FILL_BYTE   = 8'hFF;

  typedef struct packed {
    logic             cmd;        // 1: load send buffer entry
    logic [7:0]       status;
    logic [7:0]       rx_byte;
    logic [BI_W-1:0]  buf_index;
    logic [7:0]       buf_value;
  } item_t;

  typedef struct packed {
    logic [7:0]       device_addr_rw;
    logic [IDX_W-1:0] master_tx_length;
    logic [IDX_W-1:0] master_rx_length;
    logic [IDX_W-1:0] slave_tx_length;
  } cfg_t;

  typedef struct packed {
    logic             act;
    logic             ack_enable;
    logic             stop_cond;
    logic             tx_valid;
    logic [7:0]       tx_byte;
    logic [1:0]       bus_state;
    logic             store_valid;
    logic [SI_W-1:0]  store_index;
    logic [7:0]       store_byte;
    logic             rx_done;
    logic [IDX_W-1:0] rx_count;
  } res_t;

  function automatic logic [IDX_W-1:0] bump_idx(input logic [IDX_W-1:0] v);
    bump_idx = (v == IDX_MAX) ? IDX_MAX : v + 1'b1;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/twi_status_event_handler.sv */
// Two-wire status event handler: input register, configuration registers,
// send buffer RAM and result register. Depends on twi_seh_pkg, twi_seh_core, twi_seh_ram.
//
// Usage:
//   in_*  : one word per bus status event or send buffer load. in_tuser selects
//           the kind (0 status event, 1 buffer load).
//   out_* : exactly one result word per input word, in order: the bus command
//           (act, ack enable, stop, byte to transmit), the mode after the event,
//           an optional received byte to store and the slave receive done flag.
//   cfg_* : register writes, taken in the cycle cfg_we is high; write only while
//           no word is in flight.
// An accepted word is held in the input register, then decoded into the result
// register. Throughput: one word per cycle while out_tready is high; decode is
// a single pass, and the send buffer RAM is read ahead at the next send index so
// its data is ready for the event.
// Reset (rst_n low, synchronous): mode idle, all indices and lengths zero, no
// word held. The send buffer is not cleared; load entries before sending them.
// Stall: while out_tready is low the result is held, one more word is still
// taken into the input register, then in_tready drops.
`default_nettype none

module twi_status_event_handler
  import twi_seh_pkg::*;
#(
  parameter int SEND_DEPTH = SEND_DEPTH_DEF,
  parameter int RECV_DEPTH = RECV_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [31:0]          in_tdata,   // status[7:0], rx_byte[15:8],
                                                // buf_index[20:16], buf_value[28:21]
  input  wire logic                 in_tuser,   // cmd
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [39:0]               out_tdata,  // act, ack_enable, stop_cond, tx_valid,
                                                // tx_byte, bus_state, store_valid,
                                                // store_index, store_byte, rx_done, rx_count
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  localparam int AW = (SEND_DEPTH > 1) ? $clog2(SEND_DEPTH) : 1;

  cfg_t   cfg_r;
  logic   s1_valid_r;
  item_t  s1_item_r;
  logic   out_valid_r;
  res_t   out_res_r;
  res_t   res;
  item_t  in_item;
  logic   adv;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  assign in_item.cmd       = in_tuser;
  assign in_item.status    = in_tdata[7:0];
  assign in_item.rx_byte   = in_tdata[15:8];
  assign in_item.buf_index = in_tdata[20:16];
  assign in_item.buf_value = in_tdata[28:21];

  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEV_ADDR: cfg_r.device_addr_rw   <= cfg_wdata;
        REG_MT_LEN:   cfg_r.master_tx_length <= cfg_wdata[IDX_W-1:0];
        REG_MR_LEN:   cfg_r.master_rx_length <= cfg_wdata[IDX_W-1:0];
        REG_ST_LEN:   cfg_r.slave_tx_length  <= cfg_wdata[IDX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_item_r <= in_item;
    end
    if (adv) begin
      out_res_r <= res;
    end
  end

  twi_seh_core #(
    .SEND_DEPTH (SEND_DEPTH),
    .RECV_DEPTH (RECV_DEPTH)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv_i       (adv),
    .item_i      (s1_item_r),
    .cfg_i       (cfg_r),
    .ram_rdata_i (ram_rdata),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .res_o       (res)
  );

  twi_seh_ram #(
    .WIDTH (8),
    .DEPTH (SEND_DEPTH)
  ) u_send_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0,
                       out_res_r.rx_count,
                       out_res_r.rx_done,
                       out_res_r.store_byte,
                       out_res_r.store_index,
                       out_res_r.store_valid,
                       out_res_r.bus_state,
                       out_res_r.tx_byte,
                       out_res_r.tx_valid,
                       out_res_r.stop_cond,
                       out_res_r.ack_enable,
                       out_res_r.act};

endmodule

`default_nettype wire

/* hw/rtl/twi_seh_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No package dependencies.
`default_nettype none

module twi_seh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* hw/rtl/twi_seh_core.sv */
// Status event decode and bus state: mode, send/receive indices, send length.
// Depends on twi_seh_pkg; drives the send buffer RAM write and prefetch address.
`default_nettype none

module twi_seh_core
  import twi_seh_pkg::*;
#(
  parameter int SEND_DEPTH = SEND_DEPTH_DEF,
  parameter int RECV_DEPTH = RECV_DEPTH_DEF,
  localparam int AW = (SEND_DEPTH > 1) ? $clog2(SEND_DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          adv_i,       // item in the input register is processed
  input  wire item_t         item_i,
  input  wire cfg_t          cfg_i,
  input  wire logic [7:0]    ram_rdata_i,
  output logic               ram_we_o,
  output logic [AW-1:0]      ram_waddr_o,
  output logic [7:0]         ram_wdata_o,
  output logic [AW-1:0]      ram_raddr_o,
  output res_t               res_o
);

  localparam logic [LIM_W-1:0] SEND_LIM = LIM_W'(SEND_DEPTH);
  localparam logic [LIM_W-1:0] RECV_LIM = LIM_W'(RECV_DEPTH);

  logic [1:0]       mode_r, mode_nxt;
  logic [IDX_W-1:0] send_index_r, send_index_nxt;
  logic [IDX_W-1:0] send_length_r, send_length_nxt;
  logic [IDX_W-1:0] recv_index_r, recv_index_nxt;
  logic [7:0]       buf0_r;          // copy of entry 0 for a slave transmit restart
  logic             byp_v_r, byp_v_nxt;
  logic [7:0]       byp_d_r;

  logic [7:0]       code;
  logic             store, do_stop, mr_next, st_send, restart, fetch;
  logic             load_ok;
  logic [IDX_W-1:0] fidx;
  logic [7:0]       fbyte;
  logic [7:0]       buf_rd;
  logic [IDX_W-1:0] raddr_idx;
  logic [IDX_W+AW-1:0] raddr_ext;
  logic [BI_W+AW-1:0]  waddr_ext;
  res_t             res;

  assign code    = item_i.status & STATUS_MASK;
  assign load_ok = ({{(LIM_W-BI_W){1'b0}}, item_i.buf_index} < SEND_LIM);

  // prefetched RAM word always belongs to send_index_r; same-cycle write is bypassed
  assign buf_rd = byp_v_r ? byp_d_r : ram_rdata_i;

  always_comb begin
    res             = '0;
    res.bus_state   = mode_r;
    mode_nxt        = mode_r;
    send_index_nxt  = send_index_r;
    send_length_nxt = send_length_r;
    recv_index_nxt  = recv_index_r;
    store   = 1'b0;
    do_stop = 1'b0;
    mr_next = 1'b0;
    st_send = 1'b0;
    restart = 1'b0;
    fetch   = 1'b0;
    fidx    = send_index_r;
    fbyte   = FILL_BYTE;

    if (!item_i.cmd) begin
      unique case (code)
        ST_START, ST_REP_START: begin
          res.act         = 1'b1;
          res.tx_valid    = 1'b1;
          res.tx_byte     = cfg_i.device_addr_rw;
          send_index_nxt  = '0;
          recv_index_nxt  = '0;
          send_length_nxt = cfg_i.master_tx_length;
        end
        ST_MT_SLA_ACK, ST_MT_DATA_ACK: begin
          if (send_index_r < send_length_r) begin
            res.act      = 1'b1;
            res.tx_valid = 1'b1;
            fetch        = 1'b1;
          end else begin
            do_stop = 1'b1;
          end
        end
        ST_MR_DATA_NACK: begin
          store   = 1'b1;
          do_stop = 1'b1;
        end
        ST_MT_SLA_NACK, ST_MT_DATA_NACK, ST_MR_SLA_NACK: begin
          do_stop = 1'b1;
        end
        ST_ARB_LOST: begin
          res.act  = 1'b1;
          mode_nxt = MODE_IDLE;
        end
        ST_MR_DATA_ACK: begin
          store   = 1'b1;
          mr_next = 1'b1;
        end
        ST_MR_SLA_ACK: begin
          mr_next = 1'b1;
        end
        ST_SR_SLA_ACK, ST_SR_ARB_SLA, ST_SR_GCALL, ST_SR_ARB_GCALL: begin
          mode_nxt       = MODE_SRX;
          recv_index_nxt = '0;
          res.act        = 1'b1;
          res.ack_enable = 1'b1;
        end
        ST_SR_DATA_ACK, ST_SR_GC_ACK: begin
          store = 1'b1;
        end
        ST_SR_DATA_NACK, ST_SR_GC_NACK: begin
          res.act = 1'b1;
        end
        ST_SR_STOP: begin
          res.act        = 1'b1;
          res.ack_enable = 1'b1;
          res.rx_done    = 1'b1;
          res.rx_count   = recv_index_r;
          mode_nxt       = MODE_IDLE;
        end
        ST_ST_SLA_ACK, ST_ST_ARB_SLA: begin
          mode_nxt        = MODE_STX;
          send_length_nxt = cfg_i.slave_tx_length;
          restart         = 1'b1;
          st_send         = 1'b1;
        end
        ST_ST_DATA_ACK: begin
          st_send = 1'b1;
        end
        ST_ST_DATA_NACK, ST_ST_LAST_DATA: begin
          res.act        = 1'b1;
          res.ack_enable = 1'b1;
          mode_nxt       = MODE_IDLE;
        end
        ST_BUS_ERROR: begin
          res.act        = 1'b1;
          res.ack_enable = 1'b1;
          res.stop_cond  = 1'b1;
          mode_nxt       = MODE_IDLE;
        end
        default: begin
        end
      endcase

      if (store) begin
        if ({{(LIM_W-IDX_W){1'b0}}, recv_index_r} < RECV_LIM) begin
          res.store_valid = 1'b1;
          res.store_index = recv_index_r[SI_W-1:0];
          res.store_byte  = item_i.rx_byte;
        end
        recv_index_nxt = bump_idx(recv_index_r);
        if (code == ST_SR_DATA_ACK || code == ST_SR_GC_ACK) begin
          res.act        = 1'b1;
          res.ack_enable = ({{(LIM_W-IDX_W){1'b0}}, recv_index_nxt} < RECV_LIM);
        end
      end
      if (do_stop) begin
        res.act        = 1'b1;
        res.ack_enable = 1'b1;
        res.stop_cond  = 1'b1;
        mode_nxt       = MODE_IDLE;
      end
      if (mr_next) begin
        res.act        = 1'b1;
        res.ack_enable = (({1'b0, recv_index_nxt} + 1'b1) < {1'b0, cfg_i.master_rx_length});
      end

      // send buffer fetch; a slave transmit address match restarts at entry 0
      fetch = fetch | st_send;
      fidx  = restart ? '0 : send_index_r;
      if (fetch) begin
        if (restart) begin
          fbyte = buf0_r;
        end else if ({{(LIM_W-IDX_W){1'b0}}, send_index_r} < SEND_LIM) begin
          fbyte = buf_rd;
        end
        send_index_nxt = bump_idx(fidx);
        res.tx_byte    = fbyte;
      end
      if (st_send) begin
        res.act        = 1'b1;
        res.tx_valid   = 1'b1;
        res.ack_enable = (send_index_nxt < send_length_nxt);
      end
    end

    res.bus_state = mode_nxt;
  end

  assign res_o = res;

  // RAM write on a load, prefetch read of the index that holds after this cycle
  assign waddr_ext   = {{AW{1'b0}}, item_i.buf_index};
  assign ram_we_o    = adv_i && item_i.cmd && load_ok;
  assign ram_waddr_o = waddr_ext[AW-1:0];
  assign ram_wdata_o = item_i.buf_value;
  assign raddr_idx   = !rst_n ? '0 : (adv_i ? send_index_nxt : send_index_r);
  assign raddr_ext   = {{AW{1'b0}}, raddr_idx};
  assign ram_raddr_o = raddr_ext[AW-1:0];
  assign byp_v_nxt   = ram_we_o && (ram_waddr_o == ram_raddr_o);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_IDLE;
      send_index_r  <= '0;
      send_length_r <= '0;
      recv_index_r  <= '0;
      byp_v_r       <= 1'b0;
    end else begin
      byp_v_r <= byp_v_nxt;
      if (adv_i) begin
        mode_r        <= mode_nxt;
        send_index_r  <= send_index_nxt;
        send_length_r <= send_length_nxt;
        recv_index_r  <= recv_index_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    byp_d_r <= item_i.buf_value;
    if (ram_we_o && item_i.buf_index == '0) begin
      buf0_r <= item_i.buf_value;
    end
  end

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    adv_i && !item_i.cmd && (code == ST_START || code == ST_REP_START)
    |=> send_index_r == '0 && recv_index_r == '0)
    else $error("start did not clear indices");

  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !adv_i |=> $stable(mode_r) && $stable(send_index_r) && $stable(recv_index_r)
               && $stable(send_length_r))
    else $error("state changed without an item");

  a_store_range: assert property (@(posedge clk) disable iff (!rst_n)
    adv_i && res.store_valid |-> ({{(LIM_W-IDX_W){1'b0}}, recv_index_r} < RECV_LIM)
                                  && recv_index_nxt != recv_index_r)
    else $error("store beyond receive depth");

  a_bypass_src: assert property (@(posedge clk) disable iff (!rst_n)
    byp_v_r |-> $past(ram_we_o) && $past(adv_i))
    else $error("bypass without a buffer load");

  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    adv_i && item_i.cmd |-> !res.act && !res.tx_valid && !res.store_valid && !res.rx_done
                            && mode_nxt == mode_r)
    else $error("buffer load produced bus activity");

endmodule

`default_nettype wire
